// ===== design/shjm_pkg.sv =====
// Package for the sample histogram and jitter monitor.
// Holds the widths, codes and transaction types shared by every module.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package shjm_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;
    localparam int STAMP_BITS  = 32;
    localparam int TALLY_BITS  = 16;
    localparam int BIN_TOTAL   = 1 << SAMPLE_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX   = '1;
    localparam logic [TALLY_BITS-1:0]  LIMIT_RESET = TALLY_BITS'(1000);
    localparam logic [SAMPLE_BITS-1:0] LOW_RESET   = '1;
    localparam logic [STAMP_BITS-1:0]  MIN_RESET   = '1;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic {
        REG_CAPTURE_LIMIT = 1'b0,
        REG_UNUSED        = 1'b1
    } reg_index_t;

    typedef struct packed {
        op_t                    op;
        logic [SAMPLE_BITS-1:0] bin;
        logic [STAMP_BITS-1:0]  stamp;
    } item_t;

endpackage

`default_nettype wire

// ===== design/shjm_front.sv =====
// Front end: accepts input transactions, classifies them and queues them.
// Uses shjm_pkg; feeds shjm_back through a short queue.
`timescale 1ns / 1ps
`default_nettype none

module shjm_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           operation,
    input  wire logic [shjm_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic [shjm_pkg::STAMP_BITS-1:0]  timestamp,
    input  wire logic [shjm_pkg::SAMPLE_BITS-1:0] bin_index,
    input  wire logic                           clearing,
    output logic                                q_valid,
    output shjm_pkg::item_t                     q_item,
    input  wire logic                           q_pop
);
    import shjm_pkg::*;

    item_t                 q_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg;
    logic [QPTR_BITS-1:0]  wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg;
    logic [QPTR_BITS-1:0]  rd_ptr_next;
    logic [QPTR_BITS:0]    fill_reg;
    logic [QPTR_BITS:0]    fill_next;
    logic                  push;
    item_t                 new_item;

    always_comb
    begin
        new_item.op    = op_t'(operation);
        new_item.stamp = timestamp;
        if (op_t'(operation) == OP_READ)
        begin
            new_item.bin = bin_index;
        end
        else
        begin
            new_item.bin = sample;
        end
    end

    assign in_stall = clearing || (fill_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/shjm_back.sv =====
// Back end: histogram memory with clearing pass, bin update with forwarding,
// running statistics and the output register. Uses shjm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shjm_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [shjm_pkg::TALLY_BITS-1:0]  capture_limit,
    output logic                                  clearing,
    input  wire logic                             q_valid,
    input  wire shjm_pkg::item_t                  q_item,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [shjm_pkg::COUNT_BITS-1:0]       bin_count,
    output logic [shjm_pkg::TALLY_BITS-1:0]       captured,
    output logic                                  capture_done,
    output logic [shjm_pkg::STAMP_BITS-1:0]       jitter,
    output logic [shjm_pkg::SAMPLE_BITS-1:0]      lowest_value,
    output logic [shjm_pkg::SAMPLE_BITS-1:0]      highest_value,
    output logic [shjm_pkg::COUNT_BITS-1:0]       peak_count
);
    import shjm_pkg::*;

    logic [COUNT_BITS-1:0]  hist_mem [BIN_TOTAL];
    logic [COUNT_BITS-1:0]  rdata_reg;
    logic [SAMPLE_BITS:0]   clr_cnt_reg;

    logic                   b_valid_reg;
    item_t                  b_item_reg;

    logic                   fwd_valid_reg;
    logic [SAMPLE_BITS-1:0] fwd_addr_reg;
    logic [COUNT_BITS-1:0]  fwd_data_reg;

    logic [TALLY_BITS-1:0]  count_reg;
    logic [TALLY_BITS-1:0]  count_next;
    logic [STAMP_BITS-1:0]  last_time_reg;
    logic [STAMP_BITS-1:0]  min_int_reg;
    logic [STAMP_BITS-1:0]  min_int_next;
    logic [STAMP_BITS-1:0]  max_int_reg;
    logic [STAMP_BITS-1:0]  max_int_next;
    logic [SAMPLE_BITS-1:0] low_reg;
    logic [SAMPLE_BITS-1:0] low_next;
    logic [SAMPLE_BITS-1:0] high_reg;
    logic [SAMPLE_BITS-1:0] high_next;
    logic [COUNT_BITS-1:0]  peak_reg;
    logic [COUNT_BITS-1:0]  peak_next;

    logic                   out_valid_reg;
    logic [COUNT_BITS-1:0]  out_bin_reg;
    logic [TALLY_BITS-1:0]  out_count_reg;
    logic                   out_done_reg;
    logic                   out_two_reg;
    logic [STAMP_BITS-1:0]  out_min_reg;
    logic [STAMP_BITS-1:0]  out_max_reg;
    logic [SAMPLE_BITS-1:0] out_low_reg;
    logic [SAMPLE_BITS-1:0] out_high_reg;
    logic [COUNT_BITS-1:0]  out_peak_reg;

    logic                   out_ready;
    logic                   b_adv;
    logic                   take;
    logic [COUNT_BITS-1:0]  cur;
    logic [COUNT_BITS-1:0]  inc;
    logic [STAMP_BITS-1:0]  gap;
    logic                   mem_we;
    logic [SAMPLE_BITS-1:0] mem_waddr;
    logic [COUNT_BITS-1:0]  mem_wdata;

    assign clearing  = !clr_cnt_reg[SAMPLE_BITS];
    assign out_ready = !out_valid_reg || !out_stall;
    assign b_adv     = b_valid_reg && out_ready;
    assign q_pop     = q_valid && (!b_valid_reg || out_ready);

    // The bin read issued alongside the previous write misses it, so the
    // most recent write is forwarded.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == b_item_reg.bin))
        begin
            cur = fwd_data_reg;
        end
        else
        begin
            cur = rdata_reg;
        end
        inc  = (cur == COUNT_MAX) ? cur : cur + 1'b1;
        take = (b_item_reg.op == OP_SAMPLE) && (count_reg < capture_limit);
        gap  = b_item_reg.stamp - last_time_reg;
    end

    always_comb
    begin
        count_next   = count_reg;
        min_int_next = min_int_reg;
        max_int_next = max_int_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        peak_next    = peak_reg;
        if (take)
        begin
            count_next = count_reg + 1'b1;
            if (inc > peak_reg)
            begin
                peak_next = inc;
            end
            if (b_item_reg.bin < low_reg)
            begin
                low_next = b_item_reg.bin;
            end
            if (b_item_reg.bin > high_reg)
            begin
                high_next = b_item_reg.bin;
            end
            if (count_reg != '0)
            begin
                if (gap < min_int_reg)
                begin
                    min_int_next = gap;
                end
                if (gap > max_int_reg)
                begin
                    max_int_next = gap;
                end
            end
        end
    end

    always_comb
    begin
        if (clearing)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg[SAMPLE_BITS-1:0];
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = b_adv && take;
            mem_waddr = b_item_reg.bin;
            mem_wdata = inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop)
        begin
            rdata_reg <= hist_mem[q_item.bin];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            last_time_reg <= '0;
            min_int_reg   <= MIN_RESET;
            max_int_reg   <= '0;
            low_reg       <= LOW_RESET;
            high_reg      <= '0;
            peak_reg      <= '0;
        end
        else
        begin
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (q_pop)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (b_adv && take)
            begin
                fwd_valid_reg <= 1'b1;
                count_reg     <= count_next;
                last_time_reg <= b_item_reg.stamp;
                min_int_reg   <= min_int_next;
                max_int_reg   <= max_int_next;
                low_reg       <= low_next;
                high_reg      <= high_next;
                peak_reg      <= peak_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b_item_reg <= q_item;
        end
        if (b_adv && take)
        begin
            fwd_addr_reg <= b_item_reg.bin;
            fwd_data_reg <= inc;
        end
        if (b_adv)
        begin
            out_bin_reg   <= (b_item_reg.op == OP_READ) ? cur : '0;
            out_count_reg <= count_next;
            out_done_reg  <= (count_next >= capture_limit);
            out_two_reg   <= (count_next >= TALLY_BITS'(2));
            out_min_reg   <= min_int_next;
            out_max_reg   <= max_int_next;
            out_low_reg   <= low_next;
            out_high_reg  <= high_next;
            out_peak_reg  <= peak_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bin_count     = out_bin_reg;
    assign captured      = out_count_reg;
    assign capture_done  = out_done_reg;
    assign jitter        = out_two_reg ? (out_max_reg - out_min_reg) : '0;
    assign lowest_value  = out_low_reg;
    assign highest_value = out_high_reg;
    assign peak_count    = out_peak_reg;

    a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!b_valid_reg && !out_valid_reg))
        else $error("transaction in flight during the clearing pass");

    a_low_not_above_high: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (low_reg <= high_reg))
        else $error("lowest sample above highest sample");

    a_interval_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= TALLY_BITS'(2)) |-> (min_int_reg <= max_int_reg))
        else $error("minimum interval above maximum interval");

    a_peak_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && take) |=> (peak_reg != '0) && (count_reg != '0))
        else $error("captured sample left peak or count at zero");

endmodule

`default_nettype wire

// ===== design/sample_histogram_jitter_monitor.sv =====
// Top level of the sample histogram and jitter monitor.
// Holds the APB register and joins shjm_front and shjm_back; uses shjm_pkg.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------
//   input    | in_valid / in_stall        | operation, sample, timestamp,
//            |                            | bin_index
//   output   | out_valid / out_stall      | bin_count, captured,
//            |                            | capture_done, jitter,
//            |                            | lowest_value, highest_value,
//            |                            | peak_count
//   config   | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// One transaction per cycle is sustained while out_stall is low and no
// clearing pass runs; the last bin write is forwarded into the next update.
// Input passes through the queue, the update stage and the output register.
// After reset all 4096 bins of the histogram memory are cleared, during which
// in_stall is high; configuration writes are taken as ever.
// A four-entry queue separates the input side from the update pipeline.
`timescale 1ns / 1ps
`default_nettype none

module sample_histogram_jitter_monitor (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [shjm_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [shjm_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic      [shjm_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                      pready,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 operation,
    input  wire logic [shjm_pkg::SAMPLE_BITS-1:0]     sample,
    input  wire logic [shjm_pkg::STAMP_BITS-1:0]      timestamp,
    input  wire logic [shjm_pkg::SAMPLE_BITS-1:0]     bin_index,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic      [shjm_pkg::COUNT_BITS-1:0]      bin_count,
    output logic      [shjm_pkg::TALLY_BITS-1:0]      captured,
    output logic                                      capture_done,
    output logic      [shjm_pkg::STAMP_BITS-1:0]      jitter,
    output logic      [shjm_pkg::SAMPLE_BITS-1:0]     lowest_value,
    output logic      [shjm_pkg::SAMPLE_BITS-1:0]     highest_value,
    output logic      [shjm_pkg::COUNT_BITS-1:0]      peak_count
);
    import shjm_pkg::*;

    logic [TALLY_BITS-1:0] limit_reg;
    logic                  cfg_write;
    reg_index_t            reg_sel;
    logic                  clearing;
    logic                  q_valid;
    item_t                 q_item;
    logic                  q_pop;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[APB_ADDR_BITS-1]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_sel)
            REG_CAPTURE_LIMIT: prdata = APB_DATA_BITS'(limit_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write && (reg_sel == REG_CAPTURE_LIMIT))
        begin
            limit_reg <= pwdata[TALLY_BITS-1:0];
        end
    end

    shjm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .sample    (sample),
        .timestamp (timestamp),
        .bin_index (bin_index),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    shjm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .capture_limit (limit_reg),
        .clearing      (clearing),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .bin_count     (bin_count),
        .captured      (captured),
        .capture_done  (capture_done),
        .jitter        (jitter),
        .lowest_value  (lowest_value),
        .highest_value (highest_value),
        .peak_count    (peak_count)
    );

endmodule

`default_nettype wire
